>>> design/msd_pkg.sv
package msd_pkg;

  typedef enum logic [2:0] {
    CLS_DOT   = 3'd0,
    CLS_DASH  = 3'd1,
    CLS_SLASH = 3'd2,
    CLS_SEP   = 3'd3,
    CLS_OTHER = 3'd4
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic        eot;
  } cls_item_t;

  typedef struct packed {
    logic [3:0] bits;
    logic [2:0] count;
    logic       bad;
    logic       slash;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_ctl_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChrDot   = 8'h2E;
  localparam logic [7:0] ChrDash  = 8'h2D;
  localparam logic [7:0] ChrSlash = 8'h2F;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;

  localparam logic [2:0] MaxElems  = 3'd4;
  localparam logic [2:0] SatElems  = 3'd5;
  localparam logic [6:0] LetterSpc = 7'd32;
  localparam logic [6:0] NoLetter  = 7'd0;

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    case (c)
      ChrDot:   cls = CLS_DOT;
      ChrDash:  cls = CLS_DASH;
      ChrSlash: cls = CLS_SLASH;
      ChrSpace: cls = CLS_SEP;
      ChrLf:    cls = CLS_SEP;
      ChrCr:    cls = CLS_SEP;
      default:  cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

  // index = 2^count - 2 + bits
  function automatic logic [6:0] letter_lookup(input logic [2:0] count,
                                               input logic [3:0] bits);
    logic [4:0] base;
    logic [4:0] idx;
    logic [7:0] chr;
    case (count)
      3'd1:    base = 5'd0;
      3'd2:    base = 5'd2;
      3'd3:    base = 5'd6;
      3'd4:    base = 5'd14;
      default: base = 5'd0;
    endcase
    idx = base + {1'b0, bits};
    case (idx)
      5'd0:    chr = "E";
      5'd1:    chr = "T";
      5'd2:    chr = "I";
      5'd3:    chr = "A";
      5'd4:    chr = "N";
      5'd5:    chr = "M";
      5'd6:    chr = "S";
      5'd7:    chr = "U";
      5'd8:    chr = "R";
      5'd9:    chr = "W";
      5'd10:   chr = "D";
      5'd11:   chr = "K";
      5'd12:   chr = "G";
      5'd13:   chr = "O";
      5'd14:   chr = "H";
      5'd15:   chr = "V";
      5'd16:   chr = "F";
      5'd18:   chr = "L";
      5'd20:   chr = "P";
      5'd21:   chr = "J";
      5'd22:   chr = "B";
      5'd23:   chr = "X";
      5'd24:   chr = "C";
      5'd25:   chr = "Y";
      5'd26:   chr = "Z";
      5'd27:   chr = "Q";
      default: chr = 8'd0;
    endcase
    return chr[6:0];
  endfunction

endpackage

>>> design/msd_in_if.sv
interface msd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

>>> design/msd_out_if.sv
interface msd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] letter;

  modport source (output valid, output letter, input ready);
  modport sink   (input valid, input letter, output ready);
endinterface

>>> design/msd_front.sv
module msd_front
  import msd_pkg::*;
(
  msd_in_if.sink     in_i,
  input  logic       full_i,
  output logic       push_o,
  output cls_item_t  item_o
);

  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i;
  assign item_o.cls  = classify(in_i.char_code);
  assign item_o.eot  = in_i.end_of_text;

endmodule

>>> design/msd_queue.sv
module msd_queue
  import msd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       pop_i,
  input  cls_item_t  item_i,
  output cls_item_t  item_o,
  output queue_ctl_t ctl_o
);

  cls_item_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign ctl_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign ctl_o.empty = (cnt_q == '0);
  assign do_push     = push_i && !ctl_o.full;
  assign do_pop      = pop_i && !ctl_o.empty;
  assign item_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> design/msd_back.sv
module msd_back
  import msd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cls_item_t  item_i,
  output logic       pop_o,
  msd_out_if.source  out_o
);

  token_t     tok_q, tok_d, tok_add;
  logic       out_valid_q, out_valid_d;
  logic [6:0] letter_q, letter_d;
  logic [6:0] result;
  logic       finish;

  assign pop_o        = !empty_i && (!out_valid_q || out_o.ready);
  assign out_o.valid  = out_valid_q;
  assign out_o.letter = letter_q;

  always_comb begin
    tok_add = tok_q;
    case (item_i.cls)
      CLS_DOT, CLS_DASH: begin
        if (tok_q.slash) begin
          tok_add.bad = 1'b1;
        end
        if (tok_q.count < MaxElems) begin
          tok_add.bits = {tok_q.bits[2:0], item_i.cls == CLS_DASH};
        end
        if (tok_q.count < SatElems) begin
          tok_add.count = tok_q.count + 3'd1;
        end
      end
      CLS_SLASH: begin
        if (tok_q.slash || tok_q.count != '0) begin
          tok_add.bad = 1'b1;
        end
        tok_add.slash = 1'b1;
      end
      CLS_SEP:   tok_add = tok_q;
      default:   tok_add.bad = 1'b1;
    endcase

    result = NoLetter;
    if (!tok_add.bad) begin
      if (tok_add.slash) begin
        if (tok_add.count == '0) begin
          result = LetterSpc;
        end
      end else if (tok_add.count != '0 && tok_add.count <= MaxElems) begin
        result = letter_lookup(tok_add.count, tok_add.bits);
      end
    end

    finish = (item_i.cls == CLS_SEP) || item_i.eot;
    tok_d  = finish ? '0 : tok_add;

    out_valid_d = out_valid_q;
    letter_d    = letter_q;
    if (pop_o) begin
      out_valid_d = finish && (result != NoLetter);
      letter_d    = result;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        tok_q <= tok_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
  end

endmodule

>>> design/morse_stream_decoder.sv
// Decodes textual Morse one character per request. Space, LF and CR end a token, end_of_text
// ends it after its character; a valid token gives one uppercase letter, a lone '/' a space,
// anything else nothing. One character is taken every cycle while the queue is not full. The
// request ending a token is queued, then popped by the token logic, and its letter registered
// for output. A two-entry queue between the character classifier and the token register lets
// input keep flowing for two requests while the output is stalled.
module morse_stream_decoder
  import msd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  msd_in_if.sink     in_i,
  msd_out_if.source  out_o
);

  cls_item_t  front_item, queue_item;
  logic       front_push, back_pop;
  queue_ctl_t queue_ctl;

  msd_front u_front (
    .in_i   (in_i),
    .full_i (queue_ctl.full),
    .push_o (front_push),
    .item_o (front_item)
  );

  msd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .pop_i  (back_pop),
    .item_i (front_item),
    .item_o (queue_item),
    .ctl_o  (queue_ctl)
  );

  msd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (queue_ctl.empty),
    .item_i  (queue_item),
    .pop_o   (back_pop),
    .out_o   (out_o)
  );

endmodule

>>> design/msd_checker.sv
module msd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] letter_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(letter_i))
    else $error("result dropped or changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> letter_i == 7'd32 || (letter_i >= 7'd65 && letter_i <= 7'd90))
    else $error("letter out of range");

  // queue only fills behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without output back-pressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && !in_valid_i |-> out_valid_i)
    else $error("input stalled while output empty");

endmodule

bind morse_stream_decoder msd_checker u_msd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .letter_i    (out_o.letter)
);
